FILE: src/rbsi_pkg.sv
`timescale 1ns / 1ps
package rbsi_pkg;

    // Restoring divider: one overflow check stage, then one quotient bit per stage.
    localparam int DIV_QBITS = 32;
    localparam int DIV_LAT   = DIV_QBITS + 1;
    // Cycles spent in the merge unit behind the lanes.
    localparam int MERGE_LAT = 2;
    localparam int NUM_LANES = 6;

    localparam logic [2:0] FACE_NONE = 3'd6;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // Result of the slab merge, handed from the merge unit to the point stage.
    typedef struct packed {
        logic               hit;
        logic signed [31:0] distance;
        logic [2:0]         face;
    } t_hit_info;

endpackage

FILE: src/ray_box_slab_intersect.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake              Payload
// s_axis    in   tvalid/tready          tdata: ray origin, direction, box corners
// m_axis    out  tvalid/tready          tdata: distance, hit point, face; tuser: hit
// cfg       in   i_cfg_we (no wait)     face match tolerance, 16 bits
//
// One beat is accepted every cycle while the output side keeps up. Each beat
// passes in order through the six restoring divider lanes (one quotient bit
// per stage), the slab merge, the hit point multiply, and the point sum and
// output register. The whole pipeline advances as one; when the output beat
// is not taken, every stage holds and s_axis_tready drops. Reset clears the
// valid bits only and sets the tolerance to one LSB.
module ray_box_slab_intersect (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
    input  logic [383:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // distance, point_x, point_y, point_z, face, five zero bits
    output logic [135:0]  m_axis_tdata,
    // hit
    output logic          m_axis_tuser,
    input  logic          i_cfg_we,
    input  logic [15:0]   i_cfg_wdata
);
    import rbsi_pkg::*;

    localparam int RAY_LAT = DIV_LAT + MERGE_LAT;

    logic               w_en;
    logic signed [31:0] w_org [0:2];
    logic signed [31:0] w_dir [0:2];
    logic signed [31:0] w_lo  [0:2];
    logic signed [31:0] w_hi  [0:2];
    logic signed [31:0] w_t   [0:NUM_LANES-1];
    t_hit_info          w_info;

    logic [15:0]        r_tol;
    logic               r_vld [0:RAY_LAT-1];
    logic signed [31:0] r_org [0:RAY_LAT-1][0:2];
    logic signed [31:0] r_dir [0:RAY_LAT-1][0:2];

    logic               r_pvld;
    t_hit_info          r_pinfo;
    logic signed [63:0] r_prod [0:2];
    logic signed [31:0] r_porg [0:2];

    logic               r_ovld;
    logic               r_ohit;
    logic signed [31:0] r_odist;
    logic signed [31:0] r_opt [0:2];
    logic [2:0]         r_oface;

    logic signed [48:0] w_sum [0:2];
    logic signed [31:0] w_pt  [0:2];

    // Global stall: everything moves when the output register can take a beat.
    assign w_en          = !r_ovld || m_axis_tready;
    assign s_axis_tready = w_en;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_org[a] = s_axis_tdata[32*a +: 32];
            w_dir[a] = s_axis_tdata[32*(3+a) +: 32];
            w_lo[a]  = s_axis_tdata[32*(6+a) +: 32];
            w_hi[a]  = s_axis_tdata[32*(9+a) +: 32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= 16'd1;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    // Six lanes, one per box plane, in face order.
    for (genvar a = 0; a < 3; a++) begin : g_axis
        rbsi_div_lane u_lane_lo (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_plane (w_lo[a]),
            .i_org   (w_org[a]),
            .i_dir   (w_dir[a]),
            .o_t     (w_t[2*a])
        );
        rbsi_div_lane u_lane_hi (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_plane (w_hi[a]),
            .i_org   (w_org[a]),
            .i_dir   (w_dir[a]),
            .o_t     (w_t[2*a+1])
        );
    end

    rbsi_merge u_merge (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_t    (w_t),
        .i_tol  (r_tol),
        .o_info (w_info)
    );

    // The ray rides alongside the lanes and the merge until the point stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < RAY_LAT; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= s_axis_tvalid;
            for (int s = 1; s < RAY_LAT; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_org[0] <= w_org;
            r_dir[0] <= w_dir;
            for (int s = 1; s < RAY_LAT; s++) begin
                r_org[s] <= r_org[s-1];
                r_dir[s] <= r_dir[s-1];
            end
        end
    end

    // Point stage one: direction times distance, exact 64-bit product.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
        end else if (w_en) begin
            r_pvld <= r_vld[RAY_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pinfo <= w_info;
            for (int a = 0; a < 3; a++) begin
                r_prod[a] <= r_dir[RAY_LAT-1][a] * w_info.distance;
                r_porg[a] <= r_org[RAY_LAT-1][a];
            end
        end
    end

    // Point stage two: arithmetic shift floors the product, then origin is
    // added and the sum saturated.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_sum[a] = 49'(r_prod[a] >>> 16) + {{17{r_porg[a][31]}}, r_porg[a]};
            if (w_sum[a] > 49'sh0_7FFF_FFFF) begin
                w_pt[a] = S32_MAX;
            end else if (w_sum[a] < -49'sh0_8000_0000) begin
                w_pt[a] = S32_MIN;
            end else begin
                w_pt[a] = w_sum[a][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_ovld <= r_pvld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ohit  <= r_pinfo.hit;
            r_odist <= r_pinfo.distance;
            r_oface <= r_pinfo.face;
            for (int a = 0; a < 3; a++) begin
                // A miss reports the origin of nothing: all points zero.
                r_opt[a] <= r_pinfo.hit ? w_pt[a] : 32'sd0;
            end
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tuser  = r_ohit;
    assign m_axis_tdata  = {5'b0, r_oface, r_opt[2], r_opt[1], r_opt[0], r_odist};

endmodule

FILE: src/rbsi_div_lane.sv
`timescale 1ns / 1ps
module rbsi_div_lane (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_plane,
    input  logic signed [31:0] i_org,
    input  logic signed [31:0] i_dir,
    output logic signed [31:0] o_t
);
    import rbsi_pkg::*;

    logic signed [32:0] w_diff;
    logic [32:0]        w_mag;
    logic [31:0]        w_dmag;
    logic [48:0]        w_num;
    logic [32:0]        w_q_ext;

    logic [31:0] r_rem [0:DIV_QBITS-1];
    logic [31:0] r_num [0:DIV_QBITS-1];
    logic [31:0] r_d   [0:DIV_QBITS-1];
    logic [31:0] r_q   [0:DIV_QBITS];
    logic        r_neg [0:DIV_QBITS];
    logic        r_ovf [0:DIV_QBITS];

    always_comb begin
        w_diff = {i_plane[31], i_plane} - {i_org[31], i_org};
        w_mag  = w_diff[32] ? 33'(-w_diff) : 33'(w_diff);
        if (i_dir == 32'sd0) begin
            // A zero direction acts as the smallest positive step.
            w_dmag = 32'd1;
        end else begin
            w_dmag = i_dir[31] ? 32'(-i_dir) : 32'(i_dir);
        end
        w_num = {w_mag, 16'b0};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= {15'b0, w_num[48:32]};
            r_num[0] <= w_num[31:0];
            r_d[0]   <= w_dmag;
            r_q[0]   <= '0;
            r_neg[0] <= w_diff[32] ^ i_dir[31];
            // Quotient of 2^32 or more always saturates.
            r_ovf[0] <= ({15'b0, w_num[48:32]} >= w_dmag);
        end
    end

    for (genvar k = 1; k <= DIV_QBITS; k++) begin : g_stage
        logic [32:0] w_sh;
        logic [32:0] w_sub;
        logic        w_ge;
        always_comb begin
            w_sh  = {r_rem[k-1], r_num[k-1][31]};
            w_sub = w_sh - {1'b0, r_d[k-1]};
            w_ge  = (w_sh >= {1'b0, r_d[k-1]});
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k]   <= {r_q[k-1][30:0], w_ge};
                r_neg[k] <= r_neg[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
        if (k < DIV_QBITS) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= w_ge ? w_sub[31:0] : w_sh[31:0];
                    r_num[k] <= {r_num[k-1][30:0], 1'b0};
                    r_d[k]   <= r_d[k-1];
                end
            end
        end
    end

    always_comb begin
        w_q_ext = {1'b0, r_q[DIV_QBITS]};
        if (r_neg[DIV_QBITS]) begin
            if (r_ovf[DIV_QBITS] || (w_q_ext > 33'h0_8000_0000)) begin
                o_t = S32_MIN;
            end else begin
                o_t = 32'(-w_q_ext);
            end
        end else begin
            if (r_ovf[DIV_QBITS] || r_q[DIV_QBITS][31]) begin
                o_t = S32_MAX;
            end else begin
                o_t = r_q[DIV_QBITS];
            end
        end
    end

endmodule

FILE: src/rbsi_merge.sv
`timescale 1ns / 1ps
module rbsi_merge (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [31:0]        i_t [0:rbsi_pkg::NUM_LANES-1],
    input  logic [15:0]               i_tol,
    output rbsi_pkg::t_hit_info       o_info
);
    import rbsi_pkg::*;

    logic signed [31:0] w_mn [0:2];
    logic signed [31:0] w_mx [0:2];
    logic signed [31:0] w_near;
    logic signed [31:0] w_far;

    logic signed [31:0] r_t [0:NUM_LANES-1];
    logic signed [31:0] r_near;
    logic signed [31:0] r_far;

    logic               w_hit;
    logic signed [31:0] w_dist;
    logic [2:0]         w_face;
    logic signed [32:0] w_df;
    logic [32:0]        w_ad;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_mn[a] = (i_t[2*a] < i_t[2*a+1]) ? i_t[2*a] : i_t[2*a+1];
            w_mx[a] = (i_t[2*a] > i_t[2*a+1]) ? i_t[2*a] : i_t[2*a+1];
        end
        w_near = (w_mn[0] > w_mn[1]) ? w_mn[0] : w_mn[1];
        w_near = (w_near > w_mn[2]) ? w_near : w_mn[2];
        w_far  = (w_mx[0] < w_mx[1]) ? w_mx[0] : w_mx[1];
        w_far  = (w_far < w_mx[2]) ? w_far : w_mx[2];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t    <= i_t;
            r_near <= w_near;
            r_far  <= w_far;
        end
    end

    always_comb begin
        w_hit  = !(r_far < 32'sd0 || r_far < r_near);
        w_dist = (r_near < 32'sd0) ? r_far : r_near;
        w_face = FACE_NONE;
        w_df   = '0;
        w_ad   = '0;
        // Later planes win, so the scan keeps the last match.
        for (int i = 0; i < NUM_LANES; i++) begin
            w_df = {w_dist[31], w_dist} - {r_t[i][31], r_t[i]};
            w_ad = w_df[32] ? 33'(-w_df) : 33'(w_df);
            if (w_ad <= {17'b0, i_tol}) begin
                w_face = 3'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_info.hit      <= w_hit;
            o_info.distance <= w_hit ? w_dist : 32'sd0;
            o_info.face     <= w_hit ? w_face : FACE_NONE;
        end
    end

endmodule
